>>> rtl/rmj_pkg.sv
// types and constants shared by the radar jacobian pipeline
`timescale 1ns / 1ps

package rmj_pkg;

    localparam int QBITS   = 33;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SQ_LAT  = ROOT_W + 1;
    localparam int DIV_LAT = QBITS + 2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } jac_in_t;

    typedef struct packed {
        logic signed [31:0] range_by_px;
        logic signed [31:0] range_by_py;
        logic signed [31:0] bearing_by_px;
        logic signed [31:0] bearing_by_py;
        logic signed [31:0] rate_by_px;
        logic signed [31:0] rate_by_py;
        logic signed [31:0] rate_by_vx;
        logic signed [31:0] rate_by_vy;
        logic               singular;
        logic               overflow;
    } jac_out_t;

    typedef struct packed {
        logic [31:0] pm;
        logic [31:0] qm;
        logic [63:0] s;
        logic [63:0] dm;
        logic        p_neg;
        logic        q_neg;
        logic        q_pos;
        logic        d_neg;
        logic        sing;
    } side_t;

endpackage

>>> rtl/rmj_sqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module rmj_sqrt (
    input  logic                      clk,
    input  logic [rmj_pkg::RAD_W-1:0] rad,
    output logic [rmj_pkg::ROOT_W-1:0] root
);
    import rmj_pkg::*;

    logic [RAD_W-1:0] v_reg   [0:ROOT_W];
    logic [RAD_W-1:0] res_reg [0:ROOT_W];
    logic [RAD_W-1:0] trial   [0:ROOT_W-1];

    always_ff @(posedge clk)
    begin
        v_reg[0]   <= rad;
        res_reg[0] <= '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : gen_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);

        assign trial[k] = res_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (v_reg[k] >= trial[k])
            begin
                v_reg[k+1]   <= v_reg[k] - trial[k];
                res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                v_reg[k+1]   <= v_reg[k];
                res_reg[k+1] <= res_reg[k] >> 1;
            end
        end
    end

    assign root = res_reg[ROOT_W][ROOT_W-1:0];

endmodule

>>> rtl/rmj_div.sv
// pipelined restoring divider with signed, saturated 32-bit quotient
`timescale 1ns / 1ps

module rmj_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic               clk,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    input  logic               neg,
    output logic signed [31:0] quo,
    output logic               ovf
);
    import rmj_pkg::*;

    localparam int EXT_W = DEN_W + NUM_W;

    logic [EXT_W-1:0] hi_ext;
    logic [EXT_W-1:0] den_ext;

    logic [DEN_W-1:0] rem_reg [0:QBITS];
    logic [DEN_W-1:0] den_reg [0:QBITS];
    logic [QBITS-1:0] low_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic             big_reg [0:QBITS];
    logic             neg_reg [0:QBITS];
    logic [DEN_W:0]   t_next  [0:QBITS-1];

    logic [QBITS-1:0] limit;
    logic [QBITS-1:0] mag;
    logic             sat;

    assign hi_ext  = {{(DEN_W + QBITS){1'b0}}, num[NUM_W-1:QBITS]};
    assign den_ext = {{NUM_W{1'b0}}, den};

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= hi_ext[DEN_W-1:0];
        den_reg[0] <= den;
        low_reg[0] <= num[QBITS-1:0];
        q_reg[0]   <= '0;
        big_reg[0] <= hi_ext >= den_ext;
        neg_reg[0] <= neg;
    end

    for (genvar k = 0; k < QBITS; k++) begin : gen_step
        assign t_next[k] = {rem_reg[k], low_reg[k][QBITS-1-k]};

        always_ff @(posedge clk)
        begin
            if (t_next[k] >= {1'b0, den_reg[k]})
            begin
                rem_reg[k+1] <= DEN_W'(t_next[k] - {1'b0, den_reg[k]});
                q_reg[k+1]   <= {q_reg[k][QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1] <= t_next[k][DEN_W-1:0];
                q_reg[k+1]   <= {q_reg[k][QBITS-2:0], 1'b0};
            end
            den_reg[k+1] <= den_reg[k];
            low_reg[k+1] <= low_reg[k];
            big_reg[k+1] <= big_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    assign limit = neg_reg[QBITS] ? {2'b01, {(QBITS-2){1'b0}}} : {2'b00, {(QBITS-2){1'b1}}};
    assign sat   = big_reg[QBITS] || (q_reg[QBITS] > limit);
    assign mag   = sat ? limit : q_reg[QBITS];

    always_ff @(posedge clk)
    begin
        quo <= neg_reg[QBITS] ? 32'(-mag) : mag[31:0];
        ovf <= sat;
    end

endmodule

>>> rtl/radar_measurement_jacobian_top.sv
// top level of the radar measurement jacobian pipeline
`timescale 1ns / 1ps

// usage
// - a state word (position and velocity, signed fixed point) is taken on item at
//   each rising edge with start high and busy low; busy is always low, so a new
//   word may follow in every cycle
// - the jacobian word appears on jacobian with done high for exactly one cycle
// - throughput is one word per cycle; each word passes the 33-stage square
//   root and the 35-stage dividers, whose steps each resolve one result bit
// - words leave in the order they came in
// - reset clears the valid chain only: no word is in flight afterwards and
//   done stays low until a new word has passed through
// - the receiver cannot stall; every result is presented once and is gone
//   in the next cycle
// - zero position gives an all-zero word with singular set; saturated
//   entries set overflow

module radar_measurement_jacobian_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rmj_pkg::jac_in_t  item,
    output logic              done,
    output rmj_pkg::jac_out_t jacobian
);
    import rmj_pkg::*;

    localparam int RX_W = 32 + FRAC_BITS;
    localparam int BR_W = 32 + 2 * FRAC_BITS;
    localparam int RT_W = 96 + FRAC_BITS;

    jac_in_t            in_reg;
    logic               vld1_reg;

    logic [31:0]        pm2_reg, qm2_reg;
    logic [63:0]        pp2_reg, qq2_reg;
    logic signed [63:0] a2_reg, b2_reg;
    logic               pneg2_reg, qneg2_reg, sing2_reg, vld2_reg;

    side_t              side3_reg;
    logic               vld3_reg;
    side_t              side_dly_reg [0:SQ_LAT-1];
    logic               vld_dly_reg  [0:SQ_LAT-1];
    logic [ROOT_W-1:0]  root;

    side_t              side4_reg;
    logic [31:0]        r4_reg;
    logic [63:0]        slr4_reg, shr4_reg, qdl4_reg, qdh4_reg, pdl4_reg, pdh4_reg;
    logic               vld4_reg;

    side_t              side5_reg;
    logic [31:0]        r5_reg;
    logic [95:0]        sr5_reg, qd5_reg, pd5_reg;
    logic               vld5_reg;

    logic               sing_dly_reg [0:DIV_LAT-1];
    logic               vld_out_reg  [0:DIV_LAT-1];

    logic signed [31:0] rpx, rpy, bpx, bpy, tpx, tpy;
    logic               o_rpx, o_rpy, o_bpx, o_bpy, o_tpx, o_tpy;

    logic [31:0]        pm_next, qm_next;
    side_t              side3_next;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else
            vld1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= item;
    end

    // magnitudes and products
    assign pm_next = in_reg.pos_x[31] ? 32'(-in_reg.pos_x) : in_reg.pos_x;
    assign qm_next = in_reg.pos_y[31] ? 32'(-in_reg.pos_y) : in_reg.pos_y;

    always_ff @(posedge clk)
    begin
        pm2_reg   <= pm_next;
        qm2_reg   <= qm_next;
        pp2_reg   <= pm_next * pm_next;
        qq2_reg   <= qm_next * qm_next;
        a2_reg    <= in_reg.vel_x * in_reg.pos_y;
        b2_reg    <= in_reg.vel_y * in_reg.pos_x;
        pneg2_reg <= in_reg.pos_x[31];
        qneg2_reg <= in_reg.pos_y[31];
        sing2_reg <= (in_reg.pos_x == '0) && (in_reg.pos_y == '0);
    end

    // squared range and cross term
    always_comb
    begin
        side3_next.pm    = pm2_reg;
        side3_next.qm    = qm2_reg;
        side3_next.s     = pp2_reg + qq2_reg;
        side3_next.d_neg = a2_reg < b2_reg;
        side3_next.dm    = (a2_reg < b2_reg) ? 64'(b2_reg - a2_reg) : 64'(a2_reg - b2_reg);
        side3_next.p_neg = pneg2_reg;
        side3_next.q_neg = qneg2_reg;
        side3_next.q_pos = !qneg2_reg && (qm2_reg != '0);
        side3_next.sing  = sing2_reg;
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
    end

    rmj_sqrt u_sqrt (
        .clk  (clk),
        .rad  (side3_reg.s),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side3_reg;
        for (int i = 1; i < SQ_LAT; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];
    end

    // partial products of the wide multiplies
    always_ff @(posedge clk)
    begin
        side4_reg <= side_dly_reg[SQ_LAT-1];
        r4_reg    <= root;
        slr4_reg  <= side_dly_reg[SQ_LAT-1].s[31:0] * root;
        shr4_reg  <= side_dly_reg[SQ_LAT-1].s[63:32] * root;
        qdl4_reg  <= side_dly_reg[SQ_LAT-1].qm * side_dly_reg[SQ_LAT-1].dm[31:0];
        qdh4_reg  <= side_dly_reg[SQ_LAT-1].qm * side_dly_reg[SQ_LAT-1].dm[63:32];
        pdl4_reg  <= side_dly_reg[SQ_LAT-1].pm * side_dly_reg[SQ_LAT-1].dm[31:0];
        pdh4_reg  <= side_dly_reg[SQ_LAT-1].pm * side_dly_reg[SQ_LAT-1].dm[63:32];
    end

    always_ff @(posedge clk)
    begin
        side5_reg <= side4_reg;
        r5_reg    <= r4_reg;
        sr5_reg   <= {32'd0, slr4_reg} + {shr4_reg, 32'd0};
        qd5_reg   <= {32'd0, qdl4_reg} + {qdh4_reg, 32'd0};
        pd5_reg   <= {32'd0, pdl4_reg} + {pdh4_reg, 32'd0};
    end

    rmj_div #(.NUM_W(RX_W), .DEN_W(32)) u_div_rpx (
        .clk (clk),
        .num ({side5_reg.pm, {FRAC_BITS{1'b0}}}),
        .den (r5_reg),
        .neg (side5_reg.p_neg),
        .quo (rpx),
        .ovf (o_rpx)
    );

    rmj_div #(.NUM_W(RX_W), .DEN_W(32)) u_div_rpy (
        .clk (clk),
        .num ({side5_reg.qm, {FRAC_BITS{1'b0}}}),
        .den (r5_reg),
        .neg (side5_reg.q_neg),
        .quo (rpy),
        .ovf (o_rpy)
    );

    rmj_div #(.NUM_W(BR_W), .DEN_W(64)) u_div_bpx (
        .clk (clk),
        .num ({side5_reg.qm, {(2 * FRAC_BITS){1'b0}}}),
        .den (side5_reg.s),
        .neg (side5_reg.q_pos),
        .quo (bpx),
        .ovf (o_bpx)
    );

    rmj_div #(.NUM_W(BR_W), .DEN_W(64)) u_div_bpy (
        .clk (clk),
        .num ({side5_reg.pm, {(2 * FRAC_BITS){1'b0}}}),
        .den (side5_reg.s),
        .neg (side5_reg.p_neg),
        .quo (bpy),
        .ovf (o_bpy)
    );

    rmj_div #(.NUM_W(RT_W), .DEN_W(96)) u_div_tpx (
        .clk (clk),
        .num ({qd5_reg, {FRAC_BITS{1'b0}}}),
        .den (sr5_reg),
        .neg (side5_reg.q_neg != side5_reg.d_neg),
        .quo (tpx),
        .ovf (o_tpx)
    );

    rmj_div #(.NUM_W(RT_W), .DEN_W(96)) u_div_tpy (
        .clk (clk),
        .num ({pd5_reg, {FRAC_BITS{1'b0}}}),
        .den (sr5_reg),
        .neg (side5_reg.p_neg == side5_reg.d_neg),
        .quo (tpy),
        .ovf (o_tpy)
    );

    always_ff @(posedge clk)
    begin
        sing_dly_reg[0] <= side5_reg.sing;
        for (int i = 1; i < DIV_LAT; i++)
            sing_dly_reg[i] <= sing_dly_reg[i-1];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            for (int i = 0; i < SQ_LAT; i++)
                vld_dly_reg[i] <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
                vld_out_reg[i] <= 1'b0;
            done <= 1'b0;
        end
        else
        begin
            vld2_reg       <= vld1_reg;
            vld3_reg       <= vld2_reg;
            vld_dly_reg[0] <= vld3_reg;
            for (int i = 1; i < SQ_LAT; i++)
                vld_dly_reg[i] <= vld_dly_reg[i-1];
            vld4_reg       <= vld_dly_reg[SQ_LAT-1];
            vld5_reg       <= vld4_reg;
            vld_out_reg[0] <= vld5_reg;
            for (int i = 1; i < DIV_LAT; i++)
                vld_out_reg[i] <= vld_out_reg[i-1];
            done <= vld_out_reg[DIV_LAT-1];
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (sing_dly_reg[DIV_LAT-1])
        begin
            // all entries zero, singular set, overflow clear
            jacobian <= {{8{32'd0}}, 1'b1, 1'b0};
        end
        else
        begin
            jacobian.range_by_px   <= rpx;
            jacobian.range_by_py   <= rpy;
            jacobian.bearing_by_px <= bpx;
            jacobian.bearing_by_py <= bpy;
            jacobian.rate_by_px    <= tpx;
            jacobian.rate_by_py    <= tpy;
            jacobian.rate_by_vx    <= rpx;
            jacobian.rate_by_vy    <= rpy;
            jacobian.singular      <= 1'b0;
            jacobian.overflow      <= o_rpx | o_rpy | o_bpx | o_bpy | o_tpx | o_tpy;
        end
    end

endmodule

>>> tb/sv/radar_measurement_jacobian_top_test.sv
// self-checking testbench for the radar measurement jacobian pipeline
`timescale 1ns / 1ps

module radar_measurement_jacobian_top_test;
    import rmj_pkg::*;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 1600;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    jac_in_t  item;
    jac_out_t jacobian;

    jac_in_t  pending_words[$];
    jac_out_t jacobian_expected[$];
    int       idle_left;
    int       quiet_cycles;
    bit       failed = 0;

    radar_measurement_jacobian_top #(.FRAC_BITS(FRAC)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .jacobian(jacobian)
    );

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_quotient(bit neg, logic [127:0] num, logic [127:0] den,
                                                 ref bit ovf);
        logic [127:0] quo;
        logic [127:0] lim;
        logic [31:0]  mag;
        if (den == 0)
            return 32'd0;
        quo = num / den;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim)
        begin
            ovf = 1;
            mag = lim[31:0];
        end
        else
            mag = quo[31:0];
        return neg ? -mag : mag;
    endfunction

    function automatic jac_out_t linearise(jac_in_t st);
        jac_out_t           j;
        logic signed [65:0] a;
        logic signed [65:0] b;
        logic signed [65:0] diff;
        logic [63:0]        pm;
        logic [63:0]        qm;
        logic [63:0]        s;
        logic [63:0]        r;
        logic [63:0]        dm;
        logic [127:0]       sr;
        bit                 p_neg;
        bit                 q_neg;
        bit                 d_neg;
        bit                 ovf;
        j = '0;
        if (st.pos_x == 0 && st.pos_y == 0)
        begin
            j.singular = 1;
            return j;
        end
        p_neg = st.pos_x < 0;
        q_neg = st.pos_y < 0;
        pm = p_neg ? 64'(-66'(st.pos_x)) : 64'(st.pos_x);
        qm = q_neg ? 64'(-66'(st.pos_y)) : 64'(st.pos_y);
        s = pm * pm + qm * qm;
        r = int_sqrt(s);
        a = 66'(st.vel_x) * 66'(st.pos_y);
        b = 66'(st.vel_y) * 66'(st.pos_x);
        d_neg = a < b;
        diff = d_neg ? b - a : a - b;
        dm = diff[63:0];
        sr = 128'(s) * 128'(r);
        ovf = 0;
        j.range_by_px = sat_quotient(p_neg, 128'(pm) << FRAC, 128'(r), ovf);
        j.range_by_py = sat_quotient(q_neg, 128'(qm) << FRAC, 128'(r), ovf);
        j.bearing_by_px = sat_quotient(st.pos_y > 0, 128'(qm) << (2 * FRAC), 128'(s), ovf);
        j.bearing_by_py = sat_quotient(p_neg, 128'(pm) << (2 * FRAC), 128'(s), ovf);
        j.rate_by_px = sat_quotient(q_neg != d_neg, (128'(qm) * 128'(dm)) << FRAC, sr, ovf);
        j.rate_by_py = sat_quotient(p_neg == d_neg, (128'(pm) * 128'(dm)) << FRAC, sr, ovf);
        j.rate_by_vx = j.range_by_px;
        j.rate_by_vy = j.range_by_py;
        j.overflow = ovf;
        return j;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 255) << $urandom_range(0, 24);
            2: v = -($urandom_range(0, 255) << $urandom_range(0, 24));
            3: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
            default: v = $urandom_range(0, 1 << 20) - (1 << 19);
        endcase
        return v;
    endfunction

    task automatic add_word(logic [31:0] px, logic [31:0] py, logic [31:0] vx, logic [31:0] vy);
        jac_in_t w;
        w.pos_x = px;
        w.pos_y = py;
        w.vel_x = vx;
        w.vel_y = vy;
        pending_words.push_back(w);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t %s expected %h actual %h", $realtime, name, exp_v, act_v);
            failed = 1;
        end
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            item <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                jacobian_expected.push_back(linearise(item));
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    start <= 0;
                    idle_left <= idle_left - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    item <= pending_words.pop_front();
                    start <= 1;
                    if (pending_words.size() > 200 && $urandom_range(0, 7) == 0)
                        idle_left <= $urandom_range(1, 3);
                end
                else
                    start <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (jacobian_expected.size() == 0)
            begin
                $display("%0t unexpected word actual %h", $realtime, jacobian);
                failed = 1;
            end
            else
            begin
                jac_out_t e;
                e = jacobian_expected.pop_front();
                check_field("range_by_px", e.range_by_px, jacobian.range_by_px);
                check_field("range_by_py", e.range_by_py, jacobian.range_by_py);
                check_field("bearing_by_px", e.bearing_by_px, jacobian.bearing_by_px);
                check_field("bearing_by_py", e.bearing_by_py, jacobian.bearing_by_py);
                check_field("rate_by_px", e.rate_by_px, jacobian.rate_by_px);
                check_field("rate_by_py", e.rate_by_py, jacobian.rate_by_py);
                check_field("rate_by_vx", e.rate_by_vx, jacobian.rate_by_vx);
                check_field("rate_by_vy", e.rate_by_vy, jacobian.rate_by_vy);
                check_field("singular", 32'(e.singular), 32'(jacobian.singular));
                check_field("overflow", 32'(e.overflow), 32'(jacobian.overflow));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 0;
        // zero position, with and without velocity
        add_word(0, 0, 0, 0);
        add_word(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        // extremes of every field
        add_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // one axis zero
        add_word(32'h0001_0000, 0, 32'h0001_0000, 32'h0002_0000);
        add_word(0, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000);
        add_word(0, 1, 32'h7FFF_FFFF, 0);
        add_word(1, 0, 0, 32'h8000_0000);
        // tiny position saturates
        add_word(1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        add_word(32'hFFFF_FFFF, 2, 32'h0100_0000, 32'hFF00_0000);
        // ordinary states in every quadrant
        add_word(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
        add_word(32'hFFFD_0000, 32'h0004_0000, 32'hFFFF_0000, 32'h0002_0000);
        add_word(32'hFFFD_0000, 32'hFFFC_0000, 32'h0001_0000, 32'hFFFE_0000);
        add_word(32'h0003_0000, 32'hFFFC_0000, 32'h0000_8000, 32'h0000_4000);
        // velocity along the line of sight gives zero rate cross term
        add_word(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                add_word(0, 0, pick_value(), pick_value());
            else
                add_word(pick_value(), pick_value(), pick_value(), pick_value());
        end
        repeat (11) @(posedge clk);
        rst_n <= 1;
        wait (pending_words.size() == 0 && !start);
        wait (jacobian_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
